### sv/diplotype_enumerator_assert.svh
// ----------------------------------------------------------------------------
// diplotype_enumerator_assert.svh
// assertion macros used by the checker file dpe_checker
// ----------------------------------------------------------------------------
`ifndef DIPLOTYPE_ENUMERATOR_ASSERT_SVH
`define DIPLOTYPE_ENUMERATOR_ASSERT_SVH

// property checked on every clock edge outside reset
`define DPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define DPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/dpe_pkg.sv
// ----------------------------------------------------------------------------
// dpe_pkg
// shared types, constants and helpers of the diplotype enumerator
// ----------------------------------------------------------------------------
package dpe_pkg;

  localparam int WORD_W     = 32;
  localparam int LOCI_WIDTH = 32;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [5:0]        loci_t;
  typedef logic [5:0]        index_t;
  typedef logic [6:0]        count_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // commands to the scan unit
  typedef struct packed {
    logic load;
    logic step;
  } scan_ctrl_t;

  // scan unit status
  typedef struct packed {
    logic empty;
    logic full;
  } scan_stat_t;

  // mask of the loci in use, count saturated to the locus width
  function automatic word_t loci_mask(input loci_t n);
    logic [6:0] ns;
    word_t      m;
    ns = {1'b0, n};
    if (ns > 7'(LOCI_WIDTH)) begin
      ns = 7'(LOCI_WIDTH);
    end
    if (ns >= 7'(WORD_W)) begin
      m = '1;
    end else begin
      m = (word_t'(1) << ns[4:0]) - word_t'(1);
    end
    return m;
  endfunction

endpackage

### sv/dpe_in_if.sv
// ----------------------------------------------------------------------------
// dpe_in_if
// input channel: one genotype item of two haplotype words and a locus count
// ----------------------------------------------------------------------------
interface dpe_in_if;
  logic                 valid;
  logic                 ready;
  dpe_pkg::word_t       first_word;
  dpe_pkg::word_t       second_word;
  dpe_pkg::loci_t       loci_count;

  modport source (output valid, output first_word, output second_word,
                  output loci_count, input ready);
  modport sink   (input valid, input first_word, input second_word,
                  input loci_count, output ready);
endinterface

### sv/dpe_out_if.sv
// ----------------------------------------------------------------------------
// dpe_out_if
// output channel: one diplotype pair item
// ----------------------------------------------------------------------------
interface dpe_out_if;
  logic                 valid;
  logic                 ready;
  dpe_pkg::word_t       hap_first;
  dpe_pkg::word_t       hap_second;
  dpe_pkg::index_t      pair_index;
  dpe_pkg::count_t      pair_count;
  logic                 overflow;
  logic                 last;

  modport source (output valid, output hap_first, output hap_second,
                  output pair_index, output pair_count, output overflow,
                  output last, input ready);
  modport sink   (input valid, input hap_first, input hap_second,
                  input pair_index, input pair_count, input overflow,
                  input last, output ready);
endinterface

### sv/diplotype_enumerator.sv
// ----------------------------------------------------------------------------
// diplotype_enumerator: item accepted only when idle; the scan unit then peels
// one heterozygous locus per cycle (h loci, at most MAX_HET, else overflow),
// then one pair per cycle unless stalled, for P pairs (P = 2^(h-1), or 1)
// synchronous active-high reset clears the sequencer and the output valid
// ----------------------------------------------------------------------------
module diplotype_enumerator #(
  parameter int MAX_HET = 7
) (
  input  logic       clk,
  input  logic       rst,
  dpe_in_if.sink     genotype,
  dpe_out_if.source  pairs
);

  localparam int CW = $clog2(MAX_HET + 2);
  localparam int MW = MAX_HET - 1;

  dpe_pkg::state_t     state;
  dpe_pkg::scan_ctrl_t scan_ctrl;
  dpe_pkg::scan_stat_t scan_stat;
  logic [CW-1:0]       hcount;
  logic [MW-1:0][dpe_pkg::WORD_W-1:0] lanes;

  dpe_pkg::word_t held_first;
  dpe_pkg::word_t held_second;
  dpe_pkg::word_t held_het_mask;
  dpe_pkg::word_t het_mask_next;
  logic [MW-1:0]  pair_counter;
  logic           ovf;

  dpe_pkg::word_t  asm_first;
  dpe_pkg::word_t  asm_second;
  dpe_pkg::count_t pcnt;
  logic            m_last;
  logic            in_fire;
  logic            out_load;

  logic            out_valid;
  dpe_pkg::word_t  out_first;
  dpe_pkg::word_t  out_second;
  dpe_pkg::index_t out_index;
  dpe_pkg::count_t out_count;
  logic            out_ovf;
  logic            out_last;

  // input handshake
  assign genotype.ready = (state == dpe_pkg::ST_IDLE);
  assign in_fire        = genotype.valid && genotype.ready;
  assign het_mask_next  = (genotype.first_word ^ genotype.second_word)
                          & dpe_pkg::loci_mask(genotype.loci_count);

  // scan unit commands
  assign scan_ctrl.load = in_fire;
  assign scan_ctrl.step = (state == dpe_pkg::ST_SCAN) && !scan_stat.empty
                          && !scan_stat.full;

  dpe_scan #(.MAX_HET(MAX_HET), .CW(CW)) u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (scan_ctrl),
    .het_mask (het_mask_next),
    .stat     (scan_stat),
    .hcount   (hcount),
    .lanes    (lanes)
  );

  dpe_assemble #(.MAX_HET(MAX_HET), .MW(MW)) u_assemble (
    .first_word (held_first),
    .het_mask   (held_het_mask),
    .lanes      (lanes),
    .pair_sel   (pair_counter),
    .hap_first  (asm_first),
    .hap_second (asm_second)
  );

  // pair count and final pair detection
  assign pcnt   = dpe_pkg::count_t'(1) << (hcount - CW'(1));
  assign m_last = (dpe_pkg::count_t'(pair_counter) + dpe_pkg::count_t'(1)) == pcnt;

  assign out_load = (state == dpe_pkg::ST_EMIT) && (!out_valid || pairs.ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dpe_pkg::ST_IDLE;
    end else begin
      case (state)
        dpe_pkg::ST_IDLE: begin
          if (in_fire) begin
            state <= dpe_pkg::ST_SCAN;
          end
        end
        dpe_pkg::ST_SCAN: begin
          if (scan_stat.empty || scan_stat.full) begin
            state <= dpe_pkg::ST_EMIT;
          end
        end
        dpe_pkg::ST_EMIT: begin
          if (out_load && (ovf || (hcount < CW'(2)) || m_last)) begin
            state <= dpe_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= dpe_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // held item and pair counter
  always_ff @(posedge clk) begin
    if (in_fire) begin
      held_first    <= genotype.first_word;
      held_second   <= genotype.second_word;
      held_het_mask <= het_mask_next;
    end
    if ((state == dpe_pkg::ST_SCAN) && (scan_stat.empty || scan_stat.full)) begin
      ovf          <= !scan_stat.empty;
      pair_counter <= '0;
    end else if (out_load) begin
      pair_counter <= pair_counter + MW'(1);
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pairs.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (ovf) begin
        out_first  <= '0;
        out_second <= '0;
        out_index  <= '0;
        out_count  <= dpe_pkg::count_t'(1);
        out_ovf    <= 1'b1;
        out_last   <= 1'b1;
      end else if (hcount < CW'(2)) begin
        out_first  <= held_first;
        out_second <= held_second;
        out_index  <= '0;
        out_count  <= dpe_pkg::count_t'(1);
        out_ovf    <= 1'b0;
        out_last   <= 1'b1;
      end else begin
        out_first  <= asm_first;
        out_second <= asm_second;
        out_index  <= dpe_pkg::index_t'(pair_counter);
        out_count  <= pcnt;
        out_ovf    <= 1'b0;
        out_last   <= m_last;
      end
    end
  end

  assign pairs.valid      = out_valid;
  assign pairs.hap_first  = out_first;
  assign pairs.hap_second = out_second;
  assign pairs.pair_index = out_index;
  assign pairs.pair_count = out_count;
  assign pairs.overflow   = out_ovf;
  assign pairs.last       = out_last;

endmodule

### sv/dpe_scan.sv
// ----------------------------------------------------------------------------
// dpe_scan
// shared lowest-set-bit extractor: peels one heterozygous locus per cycle
// and keeps the one-hot position of each but the lowest in a lane
// ----------------------------------------------------------------------------
module dpe_scan #(
  parameter int MAX_HET = 7,
  parameter int CW      = $clog2(MAX_HET + 2)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dpe_pkg::scan_ctrl_t                  ctrl,
  input  dpe_pkg::word_t                       het_mask,
  output dpe_pkg::scan_stat_t                  stat,
  output logic [CW-1:0]                        hcount,
  output logic [MAX_HET-2:0][dpe_pkg::WORD_W-1:0] lanes
);

  dpe_pkg::word_t x_rem;
  dpe_pkg::word_t lsb;

  // isolate the lowest remaining heterozygous locus
  assign lsb = x_rem & (~x_rem + dpe_pkg::word_t'(1));

  assign stat.empty = (x_rem == '0);
  assign stat.full  = (hcount == CW'(MAX_HET));

  // locus counter
  always_ff @(posedge clk) begin
    if (rst) begin
      hcount <= '0;
    end else if (ctrl.load) begin
      hcount <= '0;
    end else if (ctrl.step) begin
      hcount <= hcount + CW'(1);
    end
  end

  // remaining mask and position lanes; the lowest locus needs no lane
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x_rem <= het_mask;
      lanes <= '0;
    end else if (ctrl.step) begin
      x_rem <= x_rem ^ lsb;
      for (int j = 1; j < MAX_HET; j++) begin
        if (hcount == CW'(j)) begin
          lanes[j-1] <= lsb;
        end
      end
    end
  end

endmodule

### sv/dpe_assemble.sv
// ----------------------------------------------------------------------------
// dpe_assemble
// builds one diplotype pair from the pair counter and the locus lanes
// ----------------------------------------------------------------------------
module dpe_assemble #(
  parameter int MAX_HET = 7,
  parameter int MW      = MAX_HET - 1
) (
  input  dpe_pkg::word_t                       first_word,
  input  dpe_pkg::word_t                       het_mask,
  input  logic [MW-1:0][dpe_pkg::WORD_W-1:0]   lanes,
  input  logic [MW-1:0]                        pair_sel,
  output dpe_pkg::word_t                       hap_first,
  output dpe_pkg::word_t                       hap_second
);

  dpe_pkg::word_t dep;

  // deposit counter bits onto the upper heterozygous loci
  always_comb begin
    dep = '0;
    for (int j = 0; j < MW; j++) begin
      dep = dep | (lanes[j] & {dpe_pkg::WORD_W{pair_sel[j]}});
    end
  end

  assign hap_first  = (first_word & ~het_mask) | dep;
  assign hap_second = hap_first ^ het_mask;

endmodule

### sv/dpe_checker.sv
// ----------------------------------------------------------------------------
// dpe_checker
// port-level checks of the diplotype enumerator, bound to the top level
// ----------------------------------------------------------------------------
module dpe_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] hap_first,
  input logic [31:0] hap_second,
  input logic [5:0]  pair_index,
  input logic [6:0]  pair_count,
  input logic        overflow,
  input logic        last
);

`include "diplotype_enumerator_assert.svh"

  // no item pending right after reset
  `DPE_ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid, "output valid after reset")

  // a stalled item holds
  `DPE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(hap_first) && $stable(pair_index), "stalled output item changed")

  // no new genotype taken while a run is still being delivered
  `DPE_ASSERT(a_busy_in_run, out_valid && !last |-> !in_ready, "input ready in the middle of a run")

  // overflow item has a fixed form
  `DPE_ASSERT(a_ovf_form, out_valid && overflow |-> last && (pair_count == 7'd1) && (pair_index == 6'd0) && (hap_first == 32'd0) && (hap_second == 32'd0), "malformed overflow item")

  // final pair closes the count
  `DPE_ASSERT(a_last_index, out_valid && last |-> (7'(pair_index) + 7'd1) == pair_count, "last item index does not match count")

endmodule

bind diplotype_enumerator dpe_checker u_dpe_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (genotype.ready),
  .out_valid  (pairs.valid),
  .out_ready  (pairs.ready),
  .hap_first  (pairs.hap_first),
  .hap_second (pairs.hap_second),
  .pair_index (pairs.pair_index),
  .pair_count (pairs.pair_count),
  .overflow   (pairs.overflow),
  .last       (pairs.last)
);
